### rtl/core/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge out of reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### rtl/core/pesr_pkg.sv
// Shared constants and types of the edge span rasteriser
package pesr_pkg;
    localparam int ROWS = 512;
    localparam int ROW_W = $clog2(ROWS);
    localparam logic [15:0] HALF_SEED = 16'h7FFF;
    localparam logic [7:0] SHADE_SEED = 8'h7F;
    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic left_x_we;
        logic right_x_we;
        logic left_sh_we;
        logic right_sh_we;
        logic [ROW_W-1:0] addr;
        logic [15:0] x_data;
        logic [15:0] sh_data;
    } tbl_wr_t;
endpackage

### rtl/core/pesr_divider.sv
// Restoring divider, one quotient bit per cycle, 32 by 10 bits
module pesr_divider
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [9:0]  divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [9:0]  remainder
);
    logic [31:0] q_reg;
    logic [10:0] r_reg;
    logic [9:0]  d_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [10:0] sh;
    logic [10:0] diff;

    assign sh = {r_reg[9:0], q_reg[31]};
    assign diff = sh - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg <= 6'd0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[10])
            begin
                r_reg <= diff;
                q_reg <= {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_reg <= sh;
                q_reg <= {q_reg[30:0], 1'b0};
            end
        end
    end

    assign done = busy_reg && cnt_reg == 6'd31;
    assign quotient = !diff[10] ? {q_reg[30:0], 1'b1} : {q_reg[30:0], 1'b0};
    assign remainder = !diff[10] ? diff[9:0] : sh[9:0];
endmodule

### rtl/core/pesr_tables.sv
// Four span tables with synchronous read
module pesr_tables
(
    input  logic                     clk,
    input  pesr_pkg::tbl_wr_t        wr,
    input  logic                     rd_en,
    input  logic [pesr_pkg::ROW_W-1:0] rd_addr,
    output logic [15:0]              left_x_q,
    output logic [15:0]              right_x_q,
    output logic [15:0]              left_sh_q,
    output logic [15:0]              right_sh_q
);
    logic [15:0] lx_mem [pesr_pkg::ROWS];
    logic [15:0] rx_mem [pesr_pkg::ROWS];
    logic [15:0] ls_mem [pesr_pkg::ROWS];
    logic [15:0] rs_mem [pesr_pkg::ROWS];

    always_ff @(posedge clk)
    begin
        if (wr.left_x_we)
            lx_mem[wr.addr] <= wr.x_data;
        if (wr.right_x_we)
            rx_mem[wr.addr] <= wr.x_data;
        if (wr.left_sh_we)
            ls_mem[wr.addr] <= wr.sh_data;
        if (wr.right_sh_we)
            rs_mem[wr.addr] <= wr.sh_data;
        if (rd_en)
        begin
            left_x_q <= lx_mem[rd_addr];
            right_x_q <= rx_mem[rd_addr];
            left_sh_q <= ls_mem[rd_addr];
            right_sh_q <= rs_mem[rd_addr];
        end
    end
endmodule

### rtl/core/polygon_edge_span_rasterizer.sv
// Top level of the polygon edge span rasteriser
// Input channel in_valid/in_stall carries one operation per transfer.
// A draw operation walks an edge from one end point to the other and writes
// one row per cycle into the left table (Y rising) or right table (Y falling),
// plus the matching shade table when gouraud_enable is set. Setup is a serial
// X division, followed by a serial shade division when shading is on; the walk
// then writes deltaY+1 rows. Horizontal edges write nothing and leave the
// input free. A read operation returns the four entries of read_row on the
// output channel out_valid/out_stall; the row is registered, read from the
// tables in S_RD1 and moved to the output register in S_RD2. The output
// register holds the result while out_stall is high; the input stays stalled
// until the result has been taken. Reset clears the control state and
// gouraud_enable; the tables keep whatever they held, and an entry is valid
// only once written. gouraud_enable is written through cfg_we/cfg_wdata, and
// the user must do so only while the block is idle; this is not enforced.
module polygon_edge_span_rasterizer
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               operation,
    input  logic signed [15:0] x_start,
    input  logic [8:0]         y_start,
    input  logic signed [15:0] x_end,
    input  logic [8:0]         y_end,
    input  logic [7:0]         shade_start,
    input  logic [7:0]         shade_end,
    input  logic [8:0]         read_row,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] left_x,
    output logic signed [15:0] right_x,
    output logic [15:0]        left_shade,
    output logic [15:0]        right_shade
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_XDIV  = 4'd1;
    localparam logic [3:0] S_XWAIT = 4'd2;
    localparam logic [3:0] S_SDIV  = 4'd3;
    localparam logic [3:0] S_SWAIT = 4'd4;
    localparam logic [3:0] S_WALK  = 4'd5;
    localparam logic [3:0] S_RD1   = 4'd6;
    localparam logic [3:0] S_RD2   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam int RW = pesr_pkg::ROW_W;

    logic [3:0]  state_reg, state_next;
    logic        gouraud_reg;
    logic        right_reg;
    logic        dir_up_reg;
    logic        sh_up_reg;
    logic        sh_en_reg;
    logic [15:0] x0_reg;
    logic [15:0] dx_reg;
    logic [8:0]  dy_reg;
    logic [8:0]  y_reg;
    logic [9:0]  cnt_reg;
    logic [7:0]  i1_reg;
    logic [7:0]  dsh_reg;
    logic [31:0] acc_reg;
    logic [31:0] step_reg;
    logic        cy_reg;
    logic [15:0] sacc_reg;
    logic [15:0] sstep_reg;
    logic [8:0]  rrow_reg;
    logic        rok_reg;
    logic [15:0] olx_reg, orx_reg, ols_reg, ors_reg;

    logic        div_start;
    logic [31:0] div_dividend;
    logic        div_done;
    logic [31:0] div_q;
    logic [9:0]  div_r;
    pesr_pkg::tbl_wr_t wr;
    logic [15:0] lx_q, rx_q, ls_q, rs_q;

    logic        in_xfer;
    logic        sw;
    logic signed [16:0] xs17, xe17;
    logic [15:0] half;
    logic [31:0] seed_acc, t_init, a_init;
    logic        c_init;
    logic [32:0] t33;
    logic [7:0]  sseed;

    assign in_stall = state_reg != S_IDLE;
    assign in_xfer = in_valid && !in_stall;
    assign xs17 = {x_start[15], x_start};
    assign xe17 = {x_end[15], x_end};
    assign sw = (y_end > y_start) ? (xs17 > xe17) : (xs17 < xe17);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gouraud_reg <= 1'b0;
        else if (cfg_we)
            gouraud_reg <= cfg_wdata;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (operation == pesr_pkg::OP_READ)
                        state_next = S_RD1;
                    else if (y_end != y_start)
                        state_next = S_XDIV;
                end
            end
            S_XDIV:  state_next = S_XWAIT;
            S_XWAIT: if (div_done) state_next = sh_en_reg ? S_SDIV : S_WALK;
            S_SDIV:  state_next = S_SWAIT;
            S_SWAIT: if (div_done) state_next = S_WALK;
            S_WALK:  if (cnt_reg == {1'b0, dy_reg}) state_next = S_IDLE;
            S_RD1:   state_next = S_RD2;
            S_RD2:   state_next = S_OUT;
            S_OUT:   if (!out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign div_start = state_reg == S_XDIV || state_reg == S_SDIV;
    assign div_dividend = (state_reg == S_XDIV) ? {dx_reg, 16'h0000}
                                                : {16'h0000, dsh_reg, 8'h00};

    pesr_divider u_div
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .dividend(div_dividend),
        .divisor({1'b0, dy_reg}),
        .done(div_done),
        .quotient(div_q),
        .remainder(div_r)
    );

    always_comb
    begin
        half = {7'b0, div_r[9:1]};
        if (right_reg)
            half = 16'h0000 - half;
        seed_acc = {half + pesr_pkg::HALF_SEED, x0_reg};
        if (!right_reg)
        begin
            t33 = {1'b0, seed_acc} + {1'b0, div_q[15:0], div_q[31:16]};
            c_init = t33[32];
            t_init = t33[31:0];
            a_init = {t_init[31:16], t_init[15:0] - div_q[31:16]};
        end
        else
        begin
            t33 = {1'b0, seed_acc} - {1'b0, div_q[15:0], div_q[31:16]};
            c_init = t33[32];
            t_init = t33[31:0];
            a_init = {t_init[31:16], t_init[15:0] + div_q[31:16]};
        end
        sseed = {1'b0, div_r[7:1]};
        if (!sh_up_reg)
            sseed = 8'h00 - sseed;
        sseed = sseed + pesr_pkg::SHADE_SEED;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            right_reg <= y_end < y_start;
            dir_up_reg <= (y_end > y_start) ? !sw : sw;
            x0_reg <= sw ? x_end : x_start;
            if (y_end > y_start)
                dx_reg <= sw ? (x_start - x_end) : (x_end - x_start);
            else
                dx_reg <= sw ? (x_end - x_start) : (x_start - x_end);
            dy_reg <= (y_end > y_start) ? (y_end - y_start) : (y_start - y_end);
            y_reg <= sw ? y_end : y_start;
            i1_reg <= sw ? shade_end : shade_start;
            sh_up_reg <= sw ? (shade_start >= shade_end) : (shade_end >= shade_start);
            dsh_reg <= (shade_end >= shade_start) ? (shade_end - shade_start)
                                                  : (shade_start - shade_end);
            sh_en_reg <= gouraud_reg;
            rrow_reg <= read_row;
            rok_reg <= {23'b0, read_row} < pesr_pkg::ROWS;
        end
        if (state_reg == S_XWAIT && div_done)
        begin
            step_reg <= {div_q[15:0], div_q[31:16]};
            acc_reg <= a_init;
            cy_reg <= c_init;
            cnt_reg <= '0;
        end
        if (state_reg == S_SWAIT && div_done)
        begin
            sstep_reg <= div_q[15:0];
            sacc_reg <= {i1_reg, sseed};
        end
        if (state_reg == S_WALK)
        begin
            cnt_reg <= cnt_reg + 10'd1;
            y_reg <= dir_up_reg ? y_reg + 9'd1 : y_reg - 9'd1;
            if (!right_reg)
                {cy_reg, acc_reg} <= {1'b0, acc_reg} + {1'b0, step_reg} + {32'b0, cy_reg};
            else
                {cy_reg, acc_reg} <= {1'b0, acc_reg} - {1'b0, step_reg} - {32'b0, cy_reg};
            sacc_reg <= sh_up_reg ? sacc_reg + sstep_reg : sacc_reg - sstep_reg;
        end
        if (state_reg == S_RD2)
        begin
            olx_reg <= rok_reg ? lx_q : 16'h0000;
            orx_reg <= rok_reg ? rx_q : 16'h0000;
            ols_reg <= rok_reg ? ls_q : 16'h0000;
            ors_reg <= rok_reg ? rs_q : 16'h0000;
        end
    end

    always_comb
    begin
        wr.addr = y_reg[RW-1:0];
        wr.x_data = acc_reg[15:0];
        wr.sh_data = sacc_reg;
        wr.left_x_we = state_reg == S_WALK && !right_reg;
        wr.right_x_we = state_reg == S_WALK && right_reg;
        wr.left_sh_we = wr.left_x_we && sh_en_reg;
        wr.right_sh_we = wr.right_x_we && sh_en_reg;
    end

    pesr_tables u_tables
    (
        .clk(clk),
        .wr(wr),
        .rd_en(state_reg == S_RD1),
        .rd_addr(rrow_reg[RW-1:0]),
        .left_x_q(lx_q),
        .right_x_q(rx_q),
        .left_sh_q(ls_q),
        .right_sh_q(rs_q)
    );

    assign out_valid = state_reg == S_OUT;
    assign left_x = olx_reg;
    assign right_x = orx_reg;
    assign left_shade = ols_reg;
    assign right_shade = ors_reg;
endmodule

### rtl/core/pesr_checker.sv
// Port-level checker for the edge span rasteriser, with its bind
`include "assert_macros.svh"
module pesr_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        operation,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] left_x
);
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(left_x))
    `ASSERT_IMPL(a_busy_out, clk, rst_n, out_valid, in_stall)
    `ASSERT_NEXT(a_draw_silent, clk, rst_n, in_valid && !in_stall && !operation, !out_valid)
    `ASSERT_NEXT(a_read_busy, clk, rst_n, in_valid && !in_stall && operation, in_stall)
endmodule

bind polygon_edge_span_rasterizer pesr_checker u_pesr_checker
(
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .left_x(left_x)
);
